FILE: hdl/wptc_pkg.sv
// Package for the wrapped phase tracking corrector.
// Holds table sizes, result and command codes, FSM states and the control structs.
// No dependencies; every other file of the block imports it.
`default_nettype none

package wptc_pkg;

    localparam int SLOTS      = 64;
    localparam int SLOT_BITS  = $clog2(SLOTS);
    localparam int PHASE_BITS = 16;
    localparam int ERR_BITS   = PHASE_BITS + 1;
    localparam int PROD_BITS  = 2 * ERR_BITS;
    localparam int CORR_BITS  = PHASE_BITS + 3;
    localparam int STEP_BITS  = PHASE_BITS + 4;

    localparam logic [15:0] GAIN_NOW_RESET   = 16'd26214;
    localparam logic [15:0] GAIN_TOTAL_RESET = 16'd39322;
    localparam logic [15:0] CATCHUP_RESET    = 16'd66;

    localparam logic [1:0] CFG_GAIN_NOW   = 2'd0;
    localparam logic [1:0] CFG_GAIN_TOTAL = 2'd1;
    localparam logic [1:0] CFG_CATCHUP    = 2'd2;

    localparam logic CMD_UPDATE = 1'b0;
    localparam logic CMD_FORGET = 1'b1;

    typedef enum logic [1:0] {
        RES_STARTED   = 2'd0,
        RES_RESTARTED = 2'd1,
        RES_CORRECTED = 2'd2,
        RES_FORGOTTEN = 2'd3
    } res_status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_MUL,
        ST_SUM,
        ST_CATCH_MUL,
        ST_CATCH_ROUND,
        ST_FINISH
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic in_ready;
        logic capture;
        logic forget;
        logic start;
        logic restart;
        logic track;
        logic mul;
        logic sum;
        logic catch_mul;
        logic catch_round;
        logic out_load;
    } wptc_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_valid;
        logic is_forget;
        logic hit;
        logic net_zero;
        logic step_neg;
        logic out_free;
    } wptc_stat_t;

endpackage

`default_nettype wire

FILE: hdl/wptc_ifs.sv
// Channel interfaces of the wrapped phase tracking corrector: item, result, config.
// Depends on wptc_pkg for field widths.
`default_nettype none

interface wptc_item_if import wptc_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic                  command;
    logic [5:0]            slot;
    logic [PHASE_BITS-1:0] net_phase;
    logic [PHASE_BITS-1:0] local_phase;

    modport source (output valid, output command, output slot, output net_phase,
                    output local_phase, input ready);
    modport sink   (input valid, input command, input slot, input net_phase,
                    input local_phase, output ready);
endinterface

interface wptc_result_if import wptc_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [1:0]            status;
    logic                  changed;
    logic [PHASE_BITS-1:0] target_phase;

    modport source (output valid, output status, output changed, output target_phase,
                    input ready);
    modport sink   (input valid, input status, input changed, input target_phase,
                    output ready);
endinterface

interface wptc_cfg_if ();
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: hdl/wptc_ctrl.sv
// Controller state machine of the wrapped phase tracking corrector.
// Sequences capture, table update, multiplies and result load; depends on wptc_pkg.
`default_nettype none

module wptc_ctrl
    import wptc_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire wptc_stat_t stat,
    output wptc_cmd_t       cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (stat.in_valid)
                begin
                    state_next = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (stat.is_forget || !stat.hit || stat.net_zero)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                // The datapath shows the sign of the step it is about to store.
                state_next = stat.step_neg ? ST_CATCH_MUL : ST_FINISH;
            end
            ST_CATCH_MUL:
            begin
                state_next = ST_CATCH_ROUND;
            end
            ST_CATCH_ROUND:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (stat.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd             = '0;
        cmd.in_ready    = (state_reg == ST_IDLE);
        cmd.capture     = (state_reg == ST_IDLE) && stat.in_valid;
        cmd.forget      = (state_reg == ST_DECIDE) && stat.is_forget;
        cmd.start       = (state_reg == ST_DECIDE) && !stat.is_forget && !stat.hit;
        cmd.restart     = (state_reg == ST_DECIDE) && !stat.is_forget && stat.hit
                          && stat.net_zero;
        cmd.track       = (state_reg == ST_DECIDE) && !stat.is_forget && stat.hit
                          && !stat.net_zero;
        cmd.mul         = (state_reg == ST_MUL);
        cmd.sum         = (state_reg == ST_SUM);
        cmd.catch_mul   = (state_reg == ST_CATCH_MUL);
        cmd.catch_round = (state_reg == ST_CATCH_ROUND);
        cmd.out_load    = (state_reg == ST_FINISH) && stat.out_free;
    end

endmodule

`default_nettype wire

FILE: hdl/wptc_datapath.sv
// Datapath of the wrapped phase tracking corrector: config registers, slot table,
// error arithmetic, multipliers and the output register. Depends on wptc_pkg, wptc_ifs.
`default_nettype none

module wptc_datapath
    import wptc_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    wptc_item_if.sink      item,
    wptc_result_if.source  result,
    wptc_cfg_if.sink       cfg,
    input  wire wptc_cmd_t cmd,
    output wptc_stat_t     stat
);

    // Configuration.
    logic [15:0] gain_now_reg;
    logic [15:0] gain_total_reg;
    logic [15:0] catchup_reg;

    // Slot table: valid bits in flops, phase and error sum in memory.
    logic [SLOTS-1:0]            slot_valid_reg;
    logic [PHASE_BITS-1:0]       last_mem [SLOTS];
    logic signed [ERR_BITS-1:0]  sum_mem  [SLOTS];

    // Captured item and table read.
    logic                        command_reg;
    logic [SLOT_BITS-1:0]        slot_reg;
    logic [PHASE_BITS-1:0]       net_reg;
    logic [PHASE_BITS-1:0]       loc_reg;
    logic                        hit_reg;
    logic [PHASE_BITS-1:0]       old_reg;
    logic signed [ERR_BITS-1:0]  esum_reg;

    // Arithmetic pipeline registers.
    logic [PHASE_BITS-1:0]       delta_reg;
    logic signed [ERR_BITS-1:0]  err_reg;
    logic signed [ERR_BITS-1:0]  tot_reg;
    logic signed [PROD_BITS-1:0] p_now_reg;
    logic signed [PROD_BITS-1:0] p_total_reg;
    logic [31:0]                 p_catch_reg;
    logic signed [STEP_BITS-1:0] step_reg;
    res_status_t                 status_reg;

    // Output register.
    logic                        out_valid_reg;
    res_status_t                 out_status_reg;
    logic                        out_changed_reg;
    logic [PHASE_BITS-1:0]       out_target_reg;

    logic [SLOT_BITS-1:0]        rd_slot;
    logic [PHASE_BITS-1:0]       delta_next;
    logic signed [ERR_BITS-1:0]  err_next;
    logic signed [ERR_BITS:0]    tot_wide;
    logic signed [ERR_BITS-1:0]  tot_next;
    logic signed [PROD_BITS:0]   p_sum;
    logic signed [PROD_BITS:0]   p_biased;
    logic signed [CORR_BITS-1:0] corr;
    logic signed [STEP_BITS-1:0] step_next;
    logic [32:0]                 catch_biased;
    logic [PHASE_BITS-1:0]       target_next;

    assign rd_slot = item.slot[SLOT_BITS-1:0];

    // Centering a phase by half a cycle flips its top bit.
    assign delta_next = net_reg - old_reg;
    assign err_next   = $signed({1'b0, old_reg ^ {1'b1, {(PHASE_BITS-1){1'b0}}}})
                      - $signed({1'b0, loc_reg ^ {1'b1, {(PHASE_BITS-1){1'b0}}}});
    assign tot_wide   = {err_next[ERR_BITS-1], err_next}
                      + {esum_reg[ERR_BITS-1], esum_reg};

    // The running error is dropped once its magnitude reaches a full cycle.
    always_comb
    begin
        if ((tot_wide >= $signed({2'b01, {(PHASE_BITS){1'b0}}}))
            || (tot_wide <= $signed({2'b11, {(PHASE_BITS){1'b0}}})))
        begin
            tot_next = '0;
        end
        else
        begin
            tot_next = tot_wide[ERR_BITS-1:0];
        end
    end

    // Round half up, then drop the fraction bits of the gains.
    assign p_sum     = {p_now_reg[PROD_BITS-1], p_now_reg}
                     + {p_total_reg[PROD_BITS-1], p_total_reg};
    assign p_biased  = p_sum + $signed({{(PROD_BITS-15){1'b0}}, 1'b1, 15'd0});
    assign corr      = p_biased[16 +: CORR_BITS];
    assign step_next = $signed({{(STEP_BITS-PHASE_BITS){1'b0}}, delta_reg})
                     + {{(STEP_BITS-CORR_BITS){corr[CORR_BITS-1]}}, corr};

    assign catch_biased = {1'b0, p_catch_reg} + 33'd32768;

    always_comb
    begin
        case (status_reg)
            RES_STARTED:   target_next = net_reg;
            RES_CORRECTED: target_next = loc_reg + step_reg[PHASE_BITS-1:0];
            default:       target_next = '0;
        endcase
    end

    assign cfg.ready  = 1'b1;
    assign item.ready = cmd.in_ready;

    assign stat.in_valid  = item.valid;
    assign stat.is_forget = (command_reg == CMD_FORGET);
    assign stat.hit       = hit_reg;
    assign stat.net_zero  = (net_reg == '0);
    assign stat.step_neg  = step_next[STEP_BITS-1];
    assign stat.out_free  = !out_valid_reg || result.ready;

    assign result.valid        = out_valid_reg;
    assign result.status       = out_status_reg;
    assign result.changed      = out_changed_reg;
    assign result.target_phase = out_target_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_now_reg   <= GAIN_NOW_RESET;
            gain_total_reg <= GAIN_TOTAL_RESET;
            catchup_reg    <= CATCHUP_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_GAIN_NOW:   gain_now_reg   <= cfg.data;
                CFG_GAIN_TOTAL: gain_total_reg <= cfg.data;
                CFG_CATCHUP:    catchup_reg    <= cfg.data;
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_valid_reg <= '0;
        end
        else if (cmd.forget)
        begin
            slot_valid_reg[slot_reg] <= 1'b0;
        end
        else if (cmd.start)
        begin
            slot_valid_reg[slot_reg] <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Table memory: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            last_mem[slot_reg] <= net_reg;
            sum_mem[slot_reg]  <= '0;
        end
        else if (cmd.track)
        begin
            last_mem[slot_reg] <= net_reg;
            sum_mem[slot_reg]  <= tot_next;
        end
        if (cmd.capture)
        begin
            old_reg  <= last_mem[rd_slot];
            esum_reg <= sum_mem[rd_slot];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            command_reg <= item.command;
            slot_reg    <= rd_slot;
            net_reg     <= item.net_phase;
            loc_reg     <= item.local_phase;
            hit_reg     <= slot_valid_reg[rd_slot];
        end
        if (cmd.forget)
        begin
            status_reg <= RES_FORGOTTEN;
        end
        if (cmd.start)
        begin
            status_reg <= RES_STARTED;
        end
        if (cmd.restart)
        begin
            status_reg <= RES_RESTARTED;
        end
        if (cmd.track)
        begin
            status_reg <= RES_CORRECTED;
            delta_reg  <= delta_next;
            err_reg    <= err_next;
            tot_reg    <= tot_next;
        end
        if (cmd.mul)
        begin
            p_now_reg   <= $signed({1'b0, gain_now_reg}) * err_reg;
            p_total_reg <= $signed({1'b0, gain_total_reg}) * tot_reg;
        end
        if (cmd.sum)
        begin
            step_reg <= step_next;
        end
        if (cmd.catch_mul)
        begin
            p_catch_reg <= catchup_reg * delta_reg;
        end
        if (cmd.catch_round)
        begin
            step_reg <= $signed({{(STEP_BITS-17){1'b0}}, catch_biased[32:16]});
        end
        if (cmd.out_load)
        begin
            out_status_reg  <= status_reg;
            out_changed_reg <= (status_reg == RES_CORRECTED);
            out_target_reg  <= target_next;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/wrapped_phase_tracking_corrector.sv
// Top level of the wrapped phase tracking corrector.
// Joins wptc_ctrl and wptc_datapath; depends on wptc_pkg and the interfaces in wptc_ifs.
//
//   Channel   Direction   Payload
//   item      in          command, slot, net_phase, local_phase
//   result    out         status, changed, target_phase
//   cfg       in          index, data (gain_now, gain_total, catchup_fraction)
//
// One item is worked on at a time. A forget, a new slot or a restart goes from the
// decision state straight to the finish state; a correction passes through the
// multiply and sum states, and also through the catch-up multiply and round states
// when the step comes out negative. Reset clears the valid bits at once, so items
// are taken right after it. A stalled result holds in the output register and the
// next item is still taken and worked on until its own result is due.
`default_nettype none

module wrapped_phase_tracking_corrector
    import wptc_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    wptc_item_if.sink     item,
    wptc_result_if.source result,
    wptc_cfg_if.sink      cfg
);

    wptc_cmd_t  cmd;
    wptc_stat_t stat;

    wptc_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .cmd   (cmd)
    );

    wptc_datapath u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .result (result),
        .cfg    (cfg),
        .cmd    (cmd),
        .stat   (stat)
    );

endmodule

`default_nettype wire
